// ----- rtl/ps2md_pkg.sv -----
// Types and constants for the PS/2 mouse packet decoder.
// No dependencies.
package ps2md_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2,
    PH_WHEEL  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_WHEEL_MODE    = 2'd0,
    REG_SCREEN_WIDTH  = 2'd1,
    REG_SCREEN_HEIGHT = 2'd2
  } reg_index_t;

  localparam int SIZE_BITS = 13;

  localparam int HDR_SYNC_BIT = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;
  localparam int HDR_XOVF_BIT = 6;
  localparam int HDR_YOVF_BIT = 7;

  localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd800;
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd600;

endpackage

// ----- rtl/ps2md_clamp.sv -----
// Clamps a signed cursor sum to 0 .. size-1, size limited to 1 .. 2^COORD_BITS.
// Uses ps2md_pkg for the size width.
module ps2md_clamp #(
  parameter int COORD_BITS = 12,
  parameter int SUM_BITS   = 15
) (
  input  logic signed [SUM_BITS-1:0]   pos,
  input  logic [ps2md_pkg::SIZE_BITS-1:0] size,
  output logic [COORD_BITS-1:0]        coord
);

  logic signed [SUM_BITS-1:0] size_ext;
  logic signed [SUM_BITS-1:0] lim_max;
  logic signed [SUM_BITS-1:0] lim;
  logic signed [SUM_BITS-1:0] res;

  always_comb begin
    size_ext = SUM_BITS'(size);
    lim_max  = SUM_BITS'(1) <<< COORD_BITS;
    if (size == '0) begin
      lim = SUM_BITS'(1);
    end else if (size_ext > lim_max) begin
      lim = lim_max;
    end else begin
      lim = size_ext;
    end
    if (pos < 0) begin
      res = '0;
    end else begin
      res = pos;
    end
    if (res >= lim) begin
      res = lim - SUM_BITS'(1);
    end
    coord = res[COORD_BITS-1:0];
  end

endmodule

// ----- rtl/ps2_mouse_packet_decoder_core.sv -----
// Top level of the PS/2 mouse packet decoder: byte framing, cursor update, result register.
// Depends on ps2md_pkg and ps2md_clamp.
// A packet's result word is registered and becomes valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle unless a result waits untaken; the result register and
// in_ready = !out_valid || out_ready let a new byte enter while a result is being taken.
// Reset (rst, synchronous): waiting for a header, cursor at 400/300 masked to COORD_BITS,
// held wheel value 0, 3-byte mode, screen 800 x 600, no result pending.
module ps2_mouse_packet_decoder_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             buttons,
  output logic [COORD_BITS-1:0]  pos_x,
  output logic [COORD_BITS-1:0]  pos_y,
  output logic signed [7:0]      scroll,
  output logic                   motion_dropped,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [ps2md_pkg::SIZE_BITS-1:0] cfg_data
);

  localparam int SUM_BITS = (COORD_BITS + 3 > ps2md_pkg::SIZE_BITS + 1) ?
                            COORD_BITS + 3 : ps2md_pkg::SIZE_BITS + 1;
  localparam logic [COORD_BITS-1:0] X_RESET = COORD_BITS'(400);
  localparam logic [COORD_BITS-1:0] Y_RESET = COORD_BITS'(300);

  logic                              wheel_mode;
  logic [ps2md_pkg::SIZE_BITS-1:0]   screen_width;
  logic [ps2md_pkg::SIZE_BITS-1:0]   screen_height;

  ps2md_pkg::phase_t phase, phase_next;
  logic [7:0]            header_byte;
  logic [7:0]            x_delta_byte;
  logic [7:0]            y_delta_byte;
  logic [COORD_BITS-1:0] cursor_x, cursor_x_next;
  logic [COORD_BITS-1:0] cursor_y, cursor_y_next;
  logic [7:0]            wheel_hold, wheel_hold_next;

  logic       accept;
  logic       done;
  logic       dropped;
  logic [7:0] hdr_eff;
  logic [7:0] x_eff;
  logic [7:0] y_eff;
  logic signed [SUM_BITS-1:0] sum_x;
  logic signed [SUM_BITS-1:0] sum_y;
  logic [COORD_BITS-1:0] clamp_x;
  logic [COORD_BITS-1:0] clamp_y;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_mode    <= 1'b0;
      screen_width  <= ps2md_pkg::WIDTH_RESET;
      screen_height <= ps2md_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ps2md_pkg::REG_WHEEL_MODE:    wheel_mode    <= cfg_data[0];
        ps2md_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        ps2md_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    done       = 1'b0;
    case (phase)
      ps2md_pkg::PH_HEADER: begin
        if (data_byte[ps2md_pkg::HDR_SYNC_BIT]) phase_next = ps2md_pkg::PH_X;
      end
      ps2md_pkg::PH_X: phase_next = ps2md_pkg::PH_Y;
      ps2md_pkg::PH_Y: begin
        if (wheel_mode) begin
          phase_next = ps2md_pkg::PH_WHEEL;
        end else begin
          phase_next = ps2md_pkg::PH_HEADER;
          done       = 1'b1;
        end
      end
      ps2md_pkg::PH_WHEEL: begin
        phase_next = ps2md_pkg::PH_HEADER;
        done       = 1'b1;
      end
      default: phase_next = ps2md_pkg::PH_HEADER;
    endcase
  end

  always_comb begin
    hdr_eff = header_byte;
    x_eff   = x_delta_byte;
    y_eff   = (phase == ps2md_pkg::PH_Y) ? data_byte : y_delta_byte;
    dropped = hdr_eff[ps2md_pkg::HDR_XOVF_BIT] || hdr_eff[ps2md_pkg::HDR_YOVF_BIT];
    sum_x = $signed(SUM_BITS'(cursor_x)) +
            $signed({{(SUM_BITS-8){hdr_eff[ps2md_pkg::HDR_XSIGN_BIT]}}, x_eff});
    sum_y = $signed(SUM_BITS'(cursor_y)) -
            $signed({{(SUM_BITS-8){hdr_eff[ps2md_pkg::HDR_YSIGN_BIT]}}, y_eff});
  end

  ps2md_clamp #(.COORD_BITS(COORD_BITS), .SUM_BITS(SUM_BITS)) u_clamp_x (
    .pos   (sum_x),
    .size  (screen_width),
    .coord (clamp_x)
  );

  ps2md_clamp #(.COORD_BITS(COORD_BITS), .SUM_BITS(SUM_BITS)) u_clamp_y (
    .pos   (sum_y),
    .size  (screen_height),
    .coord (clamp_y)
  );

  always_comb begin
    cursor_x_next   = cursor_x;
    cursor_y_next   = cursor_y;
    wheel_hold_next = wheel_hold;
    if (done && !dropped) begin
      cursor_x_next = clamp_x;
      cursor_y_next = clamp_y;
    end
    if (done && wheel_mode && phase == ps2md_pkg::PH_WHEEL && data_byte != 8'd0) begin
      wheel_hold_next = data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ps2md_pkg::PH_HEADER;
      header_byte  <= '0;
      x_delta_byte <= '0;
      y_delta_byte <= '0;
      cursor_x     <= X_RESET;
      cursor_y     <= Y_RESET;
      wheel_hold   <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      cursor_x   <= cursor_x_next;
      cursor_y   <= cursor_y_next;
      wheel_hold <= wheel_hold_next;
      case (phase)
        ps2md_pkg::PH_HEADER: header_byte  <= data_byte;
        ps2md_pkg::PH_X:      x_delta_byte <= data_byte;
        ps2md_pkg::PH_Y:      y_delta_byte <= data_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= done;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && done) begin
      buttons        <= hdr_eff[2:0];
      pos_x          <= cursor_x_next;
      pos_y          <= cursor_y_next;
      scroll         <= $signed(wheel_hold_next);
      motion_dropped <= dropped;
    end
  end

  a_resync: assert property (@(posedge clk) disable iff (rst)
    accept && phase == ps2md_pkg::PH_HEADER && !data_byte[ps2md_pkg::HDR_SYNC_BIT]
    |=> phase == ps2md_pkg::PH_HEADER && !out_valid)
    else $error("header without sync bit left the header phase");

  a_drop_hold: assert property (@(posedge clk) disable iff (rst)
    accept && done && dropped
    |=> $stable(cursor_x) && $stable(cursor_y) && motion_dropped)
    else $error("cursor moved on an overflowed packet");

  a_x_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && !motion_dropped && screen_width != '0 &&
    SUM_BITS'(screen_width) <= (SUM_BITS'(1) << COORD_BITS)
    |-> SUM_BITS'(pos_x) < SUM_BITS'(screen_width))
    else $error("pos_x outside screen width");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !(accept && done) |=> !out_valid)
    else $error("result word repeated");

endmodule
